FILE: hdl/bb3_pkg.sv
package bb3_pkg;

	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int IMG_WIDTH_W  = 11;
	localparam int IMG_HEIGHT_W = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [IMG_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd1024;
	localparam logic [IMG_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 16'd768;

	localparam int QUEUE_DEPTH = 4;

	localparam int COUNT_W     = 4;
	localparam int SUM_W       = 12;
	localparam int NUMER_W     = 13;
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = 18;
	localparam int PROD_W      = NUMER_W + RECIP_W;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		pixel_t     pix;
		logic [8:0] mask;
		logic       first_col;
		logic       emit;
		logic       last;
	} cmd_t;

	// ceil(2^RECIP_SHIFT / (2*count)), exact for every numerator below 2^NUMER_W
	function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] count);
		logic [RECIP_W-1:0] m;
		case (count)
			4'd1:    m = 18'd131072;
			4'd2:    m = 18'd65536;
			4'd3:    m = 18'd43691;
			4'd4:    m = 18'd32768;
			4'd6:    m = 18'd21846;
			4'd9:    m = 18'd14564;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

FILE: hdl/bb3_queue.sv
module bb3_queue #(
	parameter int DATA_W = 36
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] head_data,
	output logic              full,
	output logic              empty
);

	localparam int DEPTH = bb3_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign head_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: hdl/bb3_div.sv
module bb3_div #(
	parameter int NUM_W = 26,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;
	logic [DEN_W-1:0] rem_next;

	assign trial    = {rem_q, num_q[NUM_W-1]};
	assign diff     = trial - {1'b0, den_q};
	assign fits     = (trial >= {1'b0, den_q});
	assign rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

	assign busy = busy_q || done_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

`ifndef SYNTH
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> den_q != '0)
		else $error("divider running with zero divisor");
`endif

endmodule

FILE: hdl/bb3_front.sv
module bb3_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bb3_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [bb3_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  bb3_pkg::pixel_t                       in_pix,
	input  logic                                  flush,
	input  logic                                  q_full,
	output logic                                  q_push,
	output bb3_pkg::cmd_t                         q_cmd,
	output logic [$clog2(MAX_WIDTH)-1:0]          q_idx
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int EW_W   = $clog2(MAX_WIDTH + 1);
	localparam int H_W    = bb3_pkg::IMG_HEIGHT_W;
	localparam int POS_W  = COL_W + H_W;
	localparam int AREA_W = EW_W + H_W;

	logic [bb3_pkg::IMG_WIDTH_W-1:0]  width_q;
	logic [bb3_pkg::IMG_HEIGHT_W-1:0] height_q;
	logic                             init_q;
	logic [COL_W-1:0]                 col_q;
	logic [H_W-1:0]                   row_q;
	logic [POS_W-1:0]                 pos_q;
	logic [POS_W-1:0]                 ro_q;
	logic [COL_W-1:0]                 co_q;
	logic [POS_W-1:0]                 last_pos_q;

	logic [EW_W-1:0]   w_eff;
	logic [H_W-1:0]    h_eff;
	logic [AREA_W-1:0] area;
	logic              div_start;
	logic              div_busy;
	logic              div_done;
	logic [POS_W-1:0]  div_quo;
	logic [EW_W-1:0]   div_rem;
	logic              emit;
	logic              first_col;
	logic              at_last;
	logic              col_wrap;
	logic              co_wrap;
	logic [2:0]        rok;
	logic [2:0]        cok;
	logic [8:0]        mask;
	bb3_pkg::pixel_t   pix;

	always_comb begin
		if (width_q == '0) begin
			w_eff = EW_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = EW_W'(MAX_WIDTH);
		end else begin
			w_eff = EW_W'(width_q);
		end
		h_eff = (height_q == '0) ? H_W'(1) : height_q;
	end

	assign area      = AREA_W'(w_eff) * AREA_W'(h_eff);
	assign cfg_ready = 1'b1;
	assign div_start = init_q;
	assign in_ready  = !q_full && !div_busy && !init_q;
	assign q_push    = in_valid && in_ready;

	bb3_div #(
		.NUM_W(POS_W),
		.DEN_W(EW_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (pos_q),
		.den   (w_eff),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	always_comb begin
		emit      = (row_q > H_W'(1)) || ((row_q == H_W'(1)) && (col_q != '0));
		first_col = (col_q == '0);
		at_last   = (pos_q >= last_pos_q);
		col_wrap  = (32'(col_q) + 32'd1 >= 32'(w_eff));
		co_wrap   = (32'(co_q) + 32'd1 >= 32'(w_eff));
		pix       = (!flush && (row_q < h_eff)) ? in_pix : '0;
		rok       = {(32'(ro_q) + 32'd1 < 32'(h_eff)), 1'b1, (ro_q != '0)};
		cok       = {(32'(co_q) + 32'd1 < 32'(w_eff)), 1'b1, (co_q != '0)};
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				mask[r*3+c] = rok[r] & cok[c];
			end
		end
		q_cmd.pix       = pix;
		q_cmd.mask      = mask;
		q_cmd.first_col = first_col;
		q_cmd.emit      = emit;
		q_cmd.last      = emit && at_last;
		q_idx           = col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bb3_pkg::IMAGE_WIDTH_RST;
			height_q <= bb3_pkg::IMAGE_HEIGHT_RST;
			init_q   <= 1'b1;
			col_q    <= '0;
			row_q    <= '0;
			pos_q    <= '0;
			ro_q     <= '0;
			co_q     <= '0;
		end else begin
			init_q <= cfg_valid;
			if (cfg_valid) begin
				case (cfg_index)
					bb3_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[bb3_pkg::IMG_WIDTH_W-1:0];
					bb3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[bb3_pkg::IMG_HEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (div_done) begin
				ro_q <= div_quo;
				co_q <= div_rem[COL_W-1:0];
			end else if (q_push) begin
				if (emit && at_last) begin
					col_q <= '0;
					row_q <= '0;
					pos_q <= '0;
					ro_q  <= '0;
					co_q  <= '0;
				end else begin
					if (col_wrap) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
					if (emit) begin
						pos_q <= pos_q + 1'b1;
						if (co_wrap) begin
							co_q <= '0;
							ro_q <= ro_q + 1'b1;
						end else begin
							co_q <= co_q + 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		last_pos_q <= POS_W'(area - 1'b1);
	end

`ifndef SYNTH
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(!div_busy && !init_q) |-> (32'(co_q) < 32'(w_eff)))
		else $error("output column outside the row");
`endif

endmodule

FILE: hdl/bb3_back.sv
module bb3_back #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	output logic                         q_pop,
	input  bb3_pkg::cmd_t                head_cmd,
	input  logic [$clog2(MAX_WIDTH)-1:0] head_idx,
	output logic                         out_valid,
	input  logic                         out_ready,
	output bb3_pkg::pixel_t              out_pix,
	output logic                         frame_end
);

	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int COUNT_W     = bb3_pkg::COUNT_W;
	localparam int SUM_W       = bb3_pkg::SUM_W;
	localparam int NUMER_W     = bb3_pkg::NUMER_W;
	localparam int PROD_W      = bb3_pkg::PROD_W;
	localparam int RECIP_SHIFT = bb3_pkg::RECIP_SHIFT;

	bb3_pkg::pixel_t upper_mem  [MAX_WIDTH];
	bb3_pkg::pixel_t middle_mem [MAX_WIDTH];

	logic                 adv;
	logic                 valid_s1;
	logic                 hit_s1;
	bb3_pkg::cmd_t        cmd_s1;
	logic [COL_W-1:0]     idx_s1;
	bb3_pkg::pixel_t      top_rd_s1;
	bb3_pkg::pixel_t      mid_rd_s1;
	bb3_pkg::pixel_t      fwd_top_s1;
	bb3_pkg::pixel_t      fwd_mid_s1;
	bb3_pkg::pixel_t      win_q [9];

	bb3_pkg::pixel_t      new_col [3];
	bb3_pkg::pixel_t      sum_win [9];
	logic [SUM_W-1:0]     sum_c [3];
	logic [COUNT_W-1:0]   count_c;

	logic                 valid_s2;
	logic                 last_s2;
	logic [SUM_W-1:0]     sum_s2 [3];
	logic [COUNT_W-1:0]   count_s2;
	logic [PROD_W-1:0]    prod_c [3];

	logic                 valid_s3;
	logic                 last_s3;
	logic [PROD_W-1:0]    prod_s3 [3];

	logic                 out_valid_q;
	bb3_pkg::pixel_t      out_pix_q;
	logic                 frame_end_q;

	assign adv       = !out_valid_q || out_ready;
	assign q_pop     = adv && !q_empty;
	assign out_valid = out_valid_q;
	assign out_pix   = out_pix_q;
	assign frame_end = frame_end_q;

	always_comb begin
		new_col[0] = hit_s1 ? fwd_top_s1 : top_rd_s1;
		new_col[1] = hit_s1 ? fwd_mid_s1 : mid_rd_s1;
		new_col[2] = cmd_s1.pix;
		for (int r = 0; r < 3; r++) begin
			sum_win[r*3]   = win_q[r*3+1];
			sum_win[r*3+1] = win_q[r*3+2];
			sum_win[r*3+2] = cmd_s1.first_col ? win_q[r*3+2] : new_col[r];
		end
		for (int k = 0; k < 3; k++) begin
			sum_c[k] = '0;
			for (int t = 0; t < 9; t++) begin
				if (cmd_s1.mask[t]) begin
					sum_c[k] = sum_c[k] + SUM_W'(sum_win[t][16-8*k +: 8]);
				end
			end
		end
		count_c = COUNT_W'($countones(cmd_s1.mask));
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod_c[k] = PROD_W'(NUMER_W'({sum_s2[k], 1'b0}) + NUMER_W'(count_s2))
				* PROD_W'(bb3_pkg::recip(count_s2));
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			top_rd_s1 <= upper_mem[head_idx];
			mid_rd_s1 <= middle_mem[head_idx];
		end
		if (adv && valid_s1) begin
			upper_mem[idx_s1]  <= new_col[1];
			middle_mem[idx_s1] <= cmd_s1.pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			hit_s1      <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv) begin
			valid_s1    <= !q_empty;
			hit_s1      <= !q_empty && valid_s1 && (head_idx == idx_s1);
			valid_s2    <= valid_s1 && cmd_s1.emit;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
			if (valid_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3]   <= win_q[r*3+1];
					win_q[r*3+1] <= win_q[r*3+2];
					win_q[r*3+2] <= new_col[r];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1     <= head_cmd;
			idx_s1     <= head_idx;
			fwd_top_s1 <= new_col[1];
			fwd_mid_s1 <= cmd_s1.pix;
			last_s2    <= cmd_s1.last;
			count_s2   <= count_c;
			last_s3    <= last_s2;
			frame_end_q <= last_s3;
			for (int k = 0; k < 3; k++) begin
				sum_s2[k]  <= sum_c[k];
				prod_s3[k] <= prod_c[k];
			end
			out_pix_q.red   <= prod_s3[0][RECIP_SHIFT +: 8];
			out_pix_q.green <= prod_s3[1][RECIP_SHIFT +: 8];
			out_pix_q.blue  <= prod_s3[2][RECIP_SHIFT +: 8];
		end
	end

`ifndef SYNTH
	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s1 |-> valid_s1)
		else $error("line buffer bypass without an item in stage one");

	a_count_set: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (count_s2 == 4'd1 || count_s2 == 4'd2 || count_s2 == 4'd3 ||
			count_s2 == 4'd4 || count_s2 == 4'd6 || count_s2 == 4'd9))
		else $error("neighbour count is not a window shape");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (32'(sum_s2[0]) <= 32'(count_s2) * 32'd255))
		else $error("red sum exceeds its neighbour count");
`endif

endmodule

FILE: hdl/box_blur_3x3_rgb_top.sv
// 3x3 box blur of an RGB pixel stream in raster order. Each output pixel is the
// rounded mean, per channel, of the neighbours of its position that lie inside
// the frame (1, 2, 3, 4, 6 or 9 of them); the last output of a frame carries
// frame_end. Output lags input by image_width + 1 items, so a frame is closed
// with image_width + 1 flush items. One item is taken per clock unless the
// queue is full; its result passes through the queue, the stage registers and
// the output register, the line buffers being two simple dual-port memories of
// MAX_WIDTH pixels read into stage one ahead of the window update. Each register
// write (and reset) stops input while a bit-serial divider realigns the output
// row and column to the new width. Line buffers need no clearing: entries not
// yet written only fall on window taps outside the frame.
module box_blur_3x3_rgb_top #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bb3_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      in_red,
	input  logic [7:0]                      in_green,
	input  logic [7:0]                      in_blue,
	input  logic                            flush,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      out_red,
	output logic [7:0]                      out_green,
	output logic [7:0]                      out_blue,
	output logic                            frame_end
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CMD_W = $bits(bb3_pkg::cmd_t);
	localparam int Q_W   = CMD_W + COL_W;

	bb3_pkg::pixel_t  in_pix;
	bb3_pkg::pixel_t  out_pix;
	bb3_pkg::cmd_t    push_cmd;
	bb3_pkg::cmd_t    head_cmd;
	logic [COL_W-1:0] push_idx;
	logic [COL_W-1:0] head_idx;
	logic [Q_W-1:0]   head_data;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;

	assign in_pix.red   = in_red;
	assign in_pix.green = in_green;
	assign in_pix.blue  = in_blue;
	assign out_red      = out_pix.red;
	assign out_green    = out_pix.green;
	assign out_blue     = out_pix.blue;
	assign head_cmd     = bb3_pkg::cmd_t'(head_data[CMD_W-1:0]);
	assign head_idx     = head_data[Q_W-1:CMD_W];

	bb3_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_pix   (in_pix),
		.flush    (flush),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd),
		.q_idx    (push_idx)
	);

	bb3_queue #(
		.DATA_W(Q_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data({push_idx, push_cmd}),
		.pop      (q_pop),
		.head_data(head_data),
		.full     (q_full),
		.empty    (q_empty)
	);

	bb3_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.head_cmd (head_cmd),
		.head_idx (head_idx),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_pix  (out_pix),
		.frame_end(frame_end)
	);

endmodule

FILE: tb/tb_box_blur_3x3_rgb_top.sv
`timescale 1ns / 1ps

module tb_box_blur_3x3_rgb_top;

	localparam int MAX_W = 1024;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam logic [bb3_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [bb3_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct packed {
		bb3_pkg::pixel_t pix;
		logic            last;
	} blurred_t;

	class blurred_pixel_book;
		logic [bb3_pkg::IMG_WIDTH_W-1:0]  width_reg;
		logic [bb3_pkg::IMG_HEIGHT_W-1:0] height_reg;
		bb3_pkg::pixel_t upper_row[MAX_W];
		bb3_pkg::pixel_t middle_row[MAX_W];
		bb3_pkg::pixel_t win[9];
		int unsigned in_col, in_row, out_pos;
		blurred_t awaited_pixels[$];
		int unsigned checked, failures;

		function new();
			width_reg = bb3_pkg::IMAGE_WIDTH_RST;
			height_reg = bb3_pkg::IMAGE_HEIGHT_RST;
			foreach (upper_row[i]) begin
				upper_row[i] = '0;
				middle_row[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			in_col = 0;
			in_row = 0;
			out_pos = 0;
			checked = 0;
			failures = 0;
		endfunction

		function void write_reg(logic [bb3_pkg::CFG_INDEX_W-1:0] index,
				logic [bb3_pkg::CFG_DATA_W-1:0] data);
			if (index == bb3_pkg::REG_IMAGE_WIDTH) width_reg = data[bb3_pkg::IMG_WIDTH_W-1:0];
			else if (index == bb3_pkg::REG_IMAGE_HEIGHT) height_reg = data;
		endfunction

		function void load_column(bb3_pkg::pixel_t top, bb3_pkg::pixel_t mid,
				bb3_pkg::pixel_t bot);
			win[2] = top;
			win[5] = mid;
			win[8] = bot;
		endfunction

		function void take_pixel(bb3_pkg::pixel_t p, logic fl);
			int unsigned w, h, idx, ro, co, cnt;
			int unsigned sum[3];
			bb3_pkg::pixel_t pix, top, mid, v;
			bit emit, at_edge;
			bit rok[3], cok[3];
			blurred_t res;
			w = (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : width_reg;
			h = (height_reg == 0) ? 1 : height_reg;
			idx = (in_col >= MAX_W) ? MAX_W - 1 : in_col;
			pix = (!fl && in_row < h) ? p : '0;
			top = upper_row[idx];
			mid = middle_row[idx];
			upper_row[idx] = mid;
			middle_row[idx] = pix;
			emit = (in_row > 1) || (in_row == 1 && in_col >= 1);
			at_edge = (in_col == 0);
			for (int r = 0; r < 3; r++) begin
				win[r*3] = win[r*3+1];
				win[r*3+1] = win[r*3+2];
			end
			if (!at_edge) load_column(top, mid, pix);
			res = '0;
			if (emit) begin
				ro = out_pos / w;
				co = out_pos % w;
				rok[0] = ro > 0;
				rok[1] = 1'b1;
				rok[2] = (ro + 1) < h;
				cok[0] = co > 0;
				cok[1] = 1'b1;
				cok[2] = (co + 1) < w;
				sum = '{0, 0, 0};
				cnt = 0;
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						if (rok[r] && cok[c]) begin
							v = win[r*3+c];
							sum[0] += v.red;
							sum[1] += v.green;
							sum[2] += v.blue;
							cnt++;
						end
					end
				end
				res.pix.red   = 8'((2 * sum[0] + cnt) / (2 * cnt));
				res.pix.green = 8'((2 * sum[1] + cnt) / (2 * cnt));
				res.pix.blue  = 8'((2 * sum[2] + cnt) / (2 * cnt));
			end
			if (at_edge) load_column(top, mid, pix);
			if (in_col + 1 >= w) begin
				in_col = 0;
				in_row = (in_row + 1) & 32'hFFFF;
			end else begin
				in_col++;
			end
			if (emit) begin
				res.last = (out_pos >= w * h - 1);
				if (res.last) begin
					in_col = 0;
					in_row = 0;
					out_pos = 0;
				end else begin
					out_pos++;
				end
				awaited_pixels.push_back(res);
			end
		endfunction

		function void match_pixel(blurred_t got);
			blurred_t want;
			checked++;
			if (awaited_pixels.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected pixel r=%0d g=%0d b=%0d end=%0b", $time,
						got.pix.red, got.pix.green, got.pix.blue, got.last);
				return;
			end
			want = awaited_pixels.pop_front();
			if (got.pix.red !== want.pix.red || got.pix.green !== want.pix.green ||
					got.pix.blue !== want.pix.blue || got.last !== want.last) begin
				failures++;
				if (failures <= 10)
					$display({"%0t: pixel %0d expected r=%0d g=%0d b=%0d end=%0b,",
						" got r=%0d g=%0d b=%0d end=%0b"},
						$time, checked, want.pix.red, want.pix.green, want.pix.blue,
						want.last, got.pix.red, got.pix.green, got.pix.blue, got.last);
			end
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [bb3_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [7:0]                      in_red = '0;
	logic [7:0]                      in_green = '0;
	logic [7:0]                      in_blue = '0;
	logic                            flush = 1'b0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [7:0]                      out_red;
	logic [7:0]                      out_green;
	logic [7:0]                      out_blue;
	logic                            frame_end;

	blurred_pixel_book book = new();
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned frames_done = 0;
	int unsigned send_idle = 0;
	int unsigned stall_pct = 0;
	int unsigned cur_w, cur_h;

	box_blur_3x3_rgb_top #(.MAX_WIDTH(MAX_W)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_red(in_red),
		.in_green(in_green),
		.in_blue(in_blue),
		.flush(flush),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.frame_end(frame_end)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) book.write_reg(cfg_index, cfg_data);
		if (in_valid && in_ready) book.take_pixel({in_red, in_green, in_blue}, flush);
		if (out_valid && out_ready) book.match_pixel({out_red, out_green, out_blue, frame_end});
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			book.awaited_pixels.size());
		$display("FAILED: results differ");
		$finish;
	end

	task automatic send_pixel(input bb3_pkg::pixel_t p, input logic fl);
		if (send_idle != 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		in_red <= p.red;
		in_green <= p.green;
		in_blue <= p.blue;
		flush <= fl;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (book.awaited_pixels.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_cfg(input logic [bb3_pkg::CFG_INDEX_W-1:0] index,
			input logic [bb3_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [bb3_pkg::CFG_DATA_W-1:0] raw_w,
			input logic [bb3_pkg::CFG_DATA_W-1:0] raw_h);
		logic [bb3_pkg::IMG_WIDTH_W-1:0] w11;
		wait_for_drain();
		repeat (16) @(posedge clk);
		write_cfg(bb3_pkg::REG_IMAGE_WIDTH, raw_w);
		write_cfg(bb3_pkg::REG_IMAGE_HEIGHT, raw_h);
		w11 = raw_w[bb3_pkg::IMG_WIDTH_W-1:0];
		cur_w = (w11 == 0) ? 1 : (w11 > MAX_W) ? MAX_W : w11;
		cur_h = (raw_h == 0) ? 1 : raw_h;
	endtask

	task automatic run_frame(input int unsigned w, input int unsigned h, input bit pause_mid);
		int unsigned n, hold_at;
		bb3_pkg::pixel_t p;
		logic fl;
		hold_at = pause_mid ? $urandom_range(w * h + w) : w * h + w + 5;
		for (n = 0; n < w * h + w + 1; n++) begin
			if (n == hold_at) wait_for_drain();
			p = bb3_pkg::pixel_t'($urandom);
			if ($urandom_range(9) == 0)
				p = {{8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
					{8{1'($urandom_range(1))}}};
			if (n < w * h) fl = ($urandom_range(99) < 4);
			else fl = ($urandom_range(99) < 85);
			send_pixel(p, fl);
		end
		frames_done++;
	endtask

	task automatic random_phase(input int unsigned idle_arg, input int unsigned stall_arg,
			input int unsigned quota);
		int unsigned start, w, h;
		bit first;
		send_idle = idle_arg;
		stall_pct <= stall_arg;
		start = items_sent;
		first = 1'b1;
		while (items_sent - start < quota) begin
			if (first || $urandom_range(1)) begin
				case ($urandom_range(9))
					0: w = 1;
					1: w = 0;
					2: w = $urandom_range(13, 40);
					default: w = $urandom_range(2, 12);
				endcase
				case ($urandom_range(9))
					0: h = 1;
					1: h = 0;
					2: h = $urandom_range(9, 16);
					default: h = $urandom_range(2, 8);
				endcase
				configure({5'($urandom), 11'(w)}, 16'(h));
				first = 1'b0;
			end
			run_frame(cur_w, cur_h, $urandom_range(4) == 0);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// width zero and height zero: single pixel frame
		configure(16'd0, 16'd0);
		send_pixel(24'hFFFFFF, 1'b0);
		send_pixel(24'h000000, 1'b1);
		send_pixel(24'h00FF00, 1'b0);
		frames_done++;

		configure(16'd2, 16'd2);
		send_pixel(24'hFF00FF, 1'b0);
		send_pixel(24'h00FF00, 1'b0);
		send_pixel(24'hFFFFFF, 1'b1);
		send_pixel(24'hFFFFFF, 1'b0);
		send_pixel(24'h000000, 1'b1);
		send_pixel(24'h000000, 1'b1);
		send_pixel(24'h0C2238, 1'b0);
		frames_done++;

		// spare indexes must leave the size alone
		configure(16'd3, 16'd1);
		write_cfg(REG_SPARE_2, 16'hFFFF);
		write_cfg(REG_SPARE_3, 16'h0000);
		send_pixel(24'hFFFFFF, 1'b0);
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'h8001FE, 1'b0);
		send_pixel(24'h000000, 1'b1);
		send_pixel(24'hABCDEF, 1'b0);
		send_pixel(24'h000000, 1'b1);
		send_pixel(24'h000000, 1'b1);
		frames_done++;

		random_phase(0, 0, 200);
		random_phase(45, 0, 200);
		random_phase(0, 45, 200);
		random_phase(22, 22, 200);

		// oversized width clamps to the line buffer depth; run past the first row
		send_idle = 0;
		stall_pct <= 0;
		configure(16'd2047, 16'd0);
		for (int n = 0; n < cur_w + 17; n++)
			send_pixel(bb3_pkg::pixel_t'($urandom), 1'b0);

		wait_for_drain();
		repeat (20) @(posedge clk);
		$display("%0d frames, %0d items in, %0d blurred pixels checked", frames_done,
			items_sent, book.checked);
		$display("sizes 1x1 to 40x16 and a clamped 1024-wide row, with idle and stall mixes");
		if (book.failures == 0 && book.awaited_pixels.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d results missing", book.failures,
				book.awaited_pixels.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
